// File: rtl/mpfa_pkg.sv
// Shared constants, types and helpers of the mouse packet ring buffer.
`default_nettype none

package mpfa_pkg;

  // Ring buffer geometry.
  localparam int BUF_DEPTH = 192;
  localparam int PTR_W     = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  // Bytes per mouse packet.
  localparam int PKT_BYTES = 3;

  // Controller status bits that must both be set for a byte to be kept.
  localparam int STS_READY_BIT = 0;
  localparam int STS_AUX_BIT   = 5;

  // Alignment bits of the first packet byte.
  localparam int ALIGN_SET_BIT = 3;
  localparam int ALIGN_Y_OVF   = 7;
  localparam int ALIGN_X_OVF   = 6;

  // Configuration register map (word index taken from paddr[2]).
  localparam int          CFG_ADDR_W  = 3;
  localparam logic        REG_ACK_IDX = 1'b0;
  localparam logic [7:0]  ACK_RESET   = 8'd250;

  // Input word kinds.
  localparam logic MODE_ARRIVAL = 1'b0;
  localparam logic MODE_READ    = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD1,
    ST_RD2
  } mpfa_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;        // latch the input word
    logic exec_short;  // finish an item that returns no packet
    logic cap0;        // capture first packet byte, advance cursor
    logic cap1;        // capture second packet byte, advance cursor
    logic cap2;        // capture third byte, commit read, load result
  } mpfa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;        // latched word kind
    logic cnt_ge3;     // at least one packet's worth held
    logic aligned;     // byte at the read position is a packet start
    logic out_free;    // result register can take a new word
  } mpfa_sts_t;

  // Pointer increment with wrap at the buffer depth.
  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(BUF_DEPTH - 1)) r = '0;
    else                            r = p + PTR_W'(1);
    return r;
  endfunction

  // A packet starts with bit 3 set and both overflow bits clear.
  function automatic logic first_aligned(input logic [7:0] b);
    logic r;
    r = b[ALIGN_SET_BIT] && !b[ALIGN_Y_OVF] && !b[ALIGN_X_OVF];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mpfa_ctrl.sv
// Sequencing state machine of the mouse packet ring buffer.
`default_nettype none

module mpfa_ctrl
  import mpfa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire mpfa_sts_t sts,
  output mpfa_cmd_t      cmd
);

  mpfa_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          if (sts.mode == MODE_READ && sts.cnt_ge3 && sts.aligned) state_nxt = ST_RD1;
          else                                                      state_nxt = ST_IDLE;
        end
      end
      ST_RD1: begin
        state_nxt = ST_RD2;
      end
      ST_RD2: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_tready      = 1'b0;
    cmd            = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          if (sts.mode == MODE_READ && sts.cnt_ge3 && sts.aligned) cmd.cap0 = 1'b1;
          else                                                      cmd.exec_short = 1'b1;
        end
      end
      ST_RD1: begin
        cmd.cap1 = 1'b1;
      end
      ST_RD2: begin
        cmd.cap2 = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/mpfa_dp.sv
// Datapath: byte store, pointers, fill count and result register.
`default_nettype none

module mpfa_dp
  import mpfa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire mpfa_cmd_t   cmd,
  output mpfa_sts_t        sts,
  input  wire logic [7:0]  ack_code,
  input  wire logic        in_mode,
  input  wire logic [7:0]  in_status,
  input  wire logic [7:0]  in_byte,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_bytes,
  output logic [2:0]       out_flags
);

  // Byte store.
  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] rd_data_r;

  // Latched input word.
  logic       mode_r;
  logic [7:0] status_r;
  logic [7:0] byte_r;

  // Pointers and count; cur_r is the read cursor and equals rd_ptr_r between items.
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Captured packet bytes.
  logic [7:0] b0_r, b1_r;

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_bytes_r, out_bytes_nxt;
  logic [2:0]  out_flags_r, out_flags_nxt;

  // Write port control.
  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;

  logic keep;
  logic full;
  logic cnt_ge3;

  assign keep    = status_r[STS_READY_BIT] && status_r[STS_AUX_BIT] && (byte_r != ack_code);
  assign full    = (cnt_r == CNT_W'(BUF_DEPTH));
  assign cnt_ge3 = (cnt_r >= CNT_W'(PKT_BYTES));

  // Status toward the controller.
  always_comb begin
    sts.mode     = mode_r;
    sts.cnt_ge3  = cnt_ge3;
    sts.aligned  = first_aligned(rd_data_r);
    sts.out_free = !out_valid_r || out_tready;
  end

  // Input word latch.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mode_r   <= in_mode;
      status_r <= in_status;
      byte_r   <= in_byte;
    end
  end

  // Next values of pointers, count, store write and result.
  always_comb begin
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    mem_we        = 1'b0;
    mem_waddr     = wr_ptr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_bytes_nxt = out_bytes_r;
    out_flags_nxt = out_flags_r;

    if (cmd.exec_short) begin
      out_valid_nxt = 1'b1;
      out_bytes_nxt = '0;
      out_flags_nxt = {cnt_ge3, 1'b0, 1'b0};
      if (mode_r == MODE_ARRIVAL) begin
        if (keep) begin
          // A full buffer is emptied before the byte goes in.
          mem_we     = 1'b1;
          mem_waddr  = full ? '0 : wr_ptr_r;
          wr_ptr_nxt = wrap_inc(mem_waddr);
          rd_ptr_nxt = full ? '0 : rd_ptr_r;
          cur_nxt    = full ? '0 : cur_r;
          cnt_nxt    = (full ? '0 : cnt_r) + CNT_W'(1);
          out_flags_nxt = {(cnt_nxt >= CNT_W'(PKT_BYTES)), full, 1'b0};
        end
      end else if (cnt_ge3) begin
        // Misaligned first byte: drop everything held.
        wr_ptr_nxt    = '0;
        rd_ptr_nxt    = '0;
        cur_nxt       = '0;
        cnt_nxt       = '0;
        out_flags_nxt = {1'b0, 1'b1, 1'b0};
      end
    end

    if (cmd.cap0 || cmd.cap1) begin
      cur_nxt = wrap_inc(cur_r);
    end

    if (cmd.cap2) begin
      cur_nxt       = wrap_inc(cur_r);
      rd_ptr_nxt    = cur_nxt;
      cnt_nxt       = cnt_r - CNT_W'(PKT_BYTES);
      out_valid_nxt = 1'b1;
      out_bytes_nxt = {rd_data_r, b1_r, b0_r};
      out_flags_nxt = {(cnt_nxt >= CNT_W'(PKT_BYTES)), 1'b0, 1'b1};
    end
  end

  // Store: reads are addressed by cur_nxt so rd_data_r shows the byte at cur_r.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= byte_r;
    end
    rd_data_r <= mem[cur_nxt];
  end

  // Packet byte capture.
  always_ff @(posedge clk) begin
    if (cmd.cap0) b0_r <= rd_data_r;
    if (cmd.cap1) b1_r <= rd_data_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cur_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cur_r       <= cur_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_bytes_r <= out_bytes_nxt;
    out_flags_r <= out_flags_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_bytes  = out_bytes_r;
  assign out_flags  = out_flags_r;

endmodule

`default_nettype wire

// File: rtl/mouse_packet_fifo_aligner_unit.sv
// Top level of the mouse packet ring buffer with its register port.
//
//  channel | direction | tdata (low bit first)                  | tuser (low bit first)
//  in_     | slave     | ctrl_status[7:0], rx_byte[15:8]        | mode[0]
//  out_    | master    | first[7:0], second[15:8], third[23:16] | packet_valid, flushed, waiting
//  cfg_    | APB slave | reg 0 at byte address 0: ack_code[7:0] | -
//
// A byte arrival or a read that returns no packet is finished in ST_EXEC, which loads its
// result word once the result register is free.
// A packet read steps through ST_EXEC, ST_RD1 and ST_RD2, capturing one packet byte in each:
// the byte store has a single read port and yields one byte per cycle.
// in_tready is high only between items; a waiting result holds the next item's finish.
// Reset is synchronous and active low; it empties the buffer and sets ack_code to 250.
`default_nettype none

module mouse_packet_fifo_aligner_unit
  import mpfa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration port
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready,
  // Input words
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [15:0]           in_tdata,   // ctrl_status[7:0], rx_byte[15:8]
  input  wire logic [0:0]            in_tuser,   // mode[0]
  // Result words
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [23:0]                out_tdata,  // first[7:0], second[15:8], third[23:16]
  output logic [2:0]                 out_tuser   // packet_valid[0], flushed[1], waiting[2]
);

  logic [7:0] ack_code_r, ack_code_nxt;
  logic       cfg_wr;

  mpfa_cmd_t cmd;
  mpfa_sts_t sts;

  // Register write decode.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    ack_code_nxt = ack_code_r;
    if (cfg_wr && cfg_paddr[2] == REG_ACK_IDX) ack_code_nxt = cfg_pwdata[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_code_r <= ACK_RESET;
    end else begin
      ack_code_r <= ack_code_nxt;
    end
  end

  // Register read.
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_ACK_IDX) cfg_prdata = {24'd0, ack_code_r};
  end

  mpfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mpfa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .ack_code   (ack_code_r),
    .in_mode    (in_tuser[0]),
    .in_status  (in_tdata[7:0]),
    .in_byte    (in_tdata[15:8]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_bytes  (out_tdata),
    .out_flags  (out_tuser)
  );

endmodule

`default_nettype wire

// File: rtl/mpfa_checker.sv
// Port-level checks of the mouse packet ring buffer and their binding.
`default_nettype none

module mpfa_checker
  import mpfa_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  cfg_psel,
  input wire logic                  cfg_penable,
  input wire logic                  cfg_pwrite,
  input wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input wire logic [31:0]           cfg_pwdata,
  input wire logic [31:0]           cfg_prdata,
  input wire logic                  cfg_pready,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [15:0]           in_tdata,
  input wire logic [0:0]            in_tuser,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [23:0]           out_tdata,
  input wire logic [2:0]            out_tuser
);

  // A stalled result word holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // A word without a packet carries zero bytes.
  a_zero_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 24'd0)
    else $error("non-packet word carries packet bytes");

  // Every returned packet starts on an aligned byte.
  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[3] && !out_tdata[7] && !out_tdata[6])
    else $error("packet returned with a misaligned first byte");

  // A packet and a flush never come from the same word.
  a_valid_no_flush: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1])
    else $error("packet word also reports a flush");

  // The block is ready for a word right after reset.
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("not idle after reset");

endmodule

bind mouse_packet_fifo_aligner_unit mpfa_checker u_mpfa_checker (.*);

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the mouse packet ring buffer: directed table, then random words.
`timescale 1ns / 1ps

module testbench;
  import mpfa_pkg::*;

  // One result word as the block reports it.
  typedef struct packed {
    logic       valid;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       flushed;
    logic       waiting;
  } pkt_result_t;

  // One row of the directed table; a typed row carries its own expected word.
  typedef struct packed {
    logic        mode;
    logic [7:0]  status;
    logic [7:0]  data;
    logic        typed;
    pkt_result_t expect_word;
  } stim_row_t;

  localparam int          CLK_HALF      = 5;
  localparam int          RESET_CYCLES  = 6;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          NUM_PHASES    = 4;
  localparam int          SEGS_PER_PH   = 20;
  localparam int          RING_PACKETS  = BUF_DEPTH / PKT_BYTES;
  localparam logic [7:0]  STS_KEEP      = (8'd1 << STS_READY_BIT) | (8'd1 << STS_AUX_BIT);
  localparam logic [7:0]  LEAD_SET      = 8'd1 << ALIGN_SET_BIT;
  localparam logic [7:0]  LEAD_MASK     = ~((8'd1 << ALIGN_Y_OVF) | (8'd1 << ALIGN_X_OVF));
  localparam logic [CFG_ADDR_W-1:0] ACK_REG_ADDR = CFG_ADDR_W'(4 * int'(REG_ACK_IDX));
  localparam pkt_result_t NO_RESULT     = '0;
  localparam int          DIR_ROWS      = 25;

  // Directed table: rejects, short reads, aligned packets and misaligned flushes.
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{MODE_READ,    8'h00, 8'h00, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
    '{MODE_ARRIVAL, 8'h21, 8'h08, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
    '{MODE_ARRIVAL, 8'h01, 8'h55, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
    '{MODE_ARRIVAL, 8'h20, 8'h55, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
    '{MODE_ARRIVAL, 8'hFF, 8'hFA, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
    '{MODE_ARRIVAL, 8'hFF, 8'hFF, 1'b0, NO_RESULT},
    '{MODE_READ,    8'hFF, 8'hFF, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
    '{MODE_ARRIVAL, 8'h21, 8'h00, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
    '{MODE_READ,    8'h00, 8'h00, 1'b1, '{1'b1, 8'h08, 8'hFF, 8'h00, 1'b0, 1'b0}},
    '{MODE_ARRIVAL, 8'h21, 8'h3F, 1'b0, NO_RESULT},
    '{MODE_ARRIVAL, 8'h21, 8'h80, 1'b0, NO_RESULT},
    '{MODE_ARRIVAL, 8'hE3, 8'h7F, 1'b0, NO_RESULT},
    '{MODE_READ,    8'h5A, 8'hA5, 1'b1, '{1'b1, 8'h3F, 8'h80, 8'h7F, 1'b0, 1'b0}},
    '{MODE_ARRIVAL, 8'h21, 8'h48, 1'b0, NO_RESULT},
    '{MODE_ARRIVAL, 8'h21, 8'h01, 1'b0, NO_RESULT},
    '{MODE_ARRIVAL, 8'h21, 8'h02, 1'b0, NO_RESULT},
    '{MODE_READ,    8'h00, 8'h00, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0}},
    '{MODE_ARRIVAL, 8'h21, 8'h88, 1'b0, NO_RESULT},
    '{MODE_ARRIVAL, 8'h21, 8'h08, 1'b0, NO_RESULT},
    '{MODE_ARRIVAL, 8'h21, 8'h08, 1'b0, NO_RESULT},
    '{MODE_READ,    8'h00, 8'h00, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0}},
    '{MODE_ARRIVAL, 8'h21, 8'hF7, 1'b0, NO_RESULT},
    '{MODE_ARRIVAL, 8'h21, 8'h00, 1'b0, NO_RESULT},
    '{MODE_ARRIVAL, 8'h21, 8'h00, 1'b0, NO_RESULT},
    '{MODE_READ,    8'hFF, 8'hFF, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0}}
  };

  // Idling per phase: none, sender only, receiver only, both lightly.
  localparam int PH_SEND_IDLE [NUM_PHASES] = '{0, 85, 0, 16};
  localparam int PH_RECV_STALL [NUM_PHASES] = '{0, 0, 85, 16};

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]           cfg_pwdata  = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata    = '0;  // ctrl_status[7:0], rx_byte[15:8]
  logic [0:0]            in_tuser    = '0;  // mode[0]
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [23:0]           out_tdata;         // first[7:0], second[15:8], third[23:16]
  logic [2:0]            out_tuser;         // packet_valid[0], flushed[1], waiting[2]

  // Typed expectation that travels with the word being offered.
  logic                  row_typed   = 1'b0;
  pkt_result_t           row_expect  = '0;

  // Mirror of the ring buffer and its register.
  logic [7:0]            ring_store [BUF_DEPTH];
  int                    ring_wr     = 0;
  int                    ring_rd     = 0;
  int                    ring_fill   = 0;
  logic [7:0]            ack_byte    = ACK_RESET;

  pkt_result_t           awaited_results [$];
  int                    send_idle_pct  = 0;
  int                    recv_stall_pct = 0;
  int                    fail_count     = 0;
  int                    quiet_cycles   = 0;
  int                    words_taken    = 0;
  int                    packets_seen   = 0;
  int                    flushes_seen   = 0;

  mouse_packet_fifo_aligner_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always #CLK_HALF clk = ~clk;

  // A packet starts with bit 3 set and both overflow bits clear.
  function automatic logic is_lead(input logic [7:0] b);
    return b[ALIGN_SET_BIT] && !b[ALIGN_Y_OVF] && !b[ALIGN_X_OVF];
  endfunction

  // Apply one input word to the mirrored ring buffer and return the word it should yield.
  function automatic pkt_result_t advance_ring(input logic mode, input logic [7:0] status,
                                               input logic [7:0] data);
    pkt_result_t r;
    r = '0;
    if (mode == MODE_ARRIVAL) begin
      if (status[STS_READY_BIT] && status[STS_AUX_BIT] && data != ack_byte) begin
        if (ring_fill == BUF_DEPTH) begin
          ring_wr   = 0;
          ring_rd   = 0;
          ring_fill = 0;
          r.flushed = 1'b1;
        end
        ring_store[ring_wr] = data;
        ring_wr   = (ring_wr + 1) % BUF_DEPTH;
        ring_fill = ring_fill + 1;
      end
    end else if (ring_fill >= PKT_BYTES) begin
      if (is_lead(ring_store[ring_rd])) begin
        r.valid   = 1'b1;
        r.b0      = ring_store[ring_rd];
        r.b1      = ring_store[(ring_rd + 1) % BUF_DEPTH];
        r.b2      = ring_store[(ring_rd + 2) % BUF_DEPTH];
        ring_rd   = (ring_rd + PKT_BYTES) % BUF_DEPTH;
        ring_fill = ring_fill - PKT_BYTES;
      end else begin
        ring_wr   = 0;
        ring_rd   = 0;
        ring_fill = 0;
        r.flushed = 1'b1;
      end
    end
    r.waiting = (ring_fill >= PKT_BYTES);
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Receiver: random backpressure at the rate of the current phase.
  always @(posedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: check result words, mirror accepted input words and register writes.
  always @(posedge clk) begin
    pkt_result_t got;
    pkt_result_t want;
    logic        busy;
    if (rst_n) begin
      busy = 1'b0;
      if (out_tvalid && out_tready) begin
        busy        = 1'b1;
        got.valid   = out_tuser[0];
        got.flushed = out_tuser[1];
        got.waiting = out_tuser[2];
        got.b0      = out_tdata[7:0];
        got.b1      = out_tdata[15:8];
        got.b2      = out_tdata[23:16];
        if (awaited_results.size() == 0) begin
          $error("result word arrived with nothing expected");
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("packet_valid", want.valid, got.valid);
          check_field("pkt_byte_first", want.b0, got.b0);
          check_field("pkt_byte_second", want.b1, got.b1);
          check_field("pkt_byte_third", want.b2, got.b2);
          check_field("flushed", want.flushed, got.flushed);
          check_field("packet_waiting", want.waiting, got.waiting);
          packets_seen += want.valid;
          flushes_seen += want.flushed;
        end
      end
      if (in_tvalid && in_tready) begin
        busy = 1'b1;
        want = advance_ring(in_tuser[0], in_tdata[7:0], in_tdata[15:8]);
        if (row_typed) want = row_expect;
        awaited_results.push_back(want);
        words_taken++;
      end
      if (cfg_psel && cfg_penable && cfg_pready) begin
        busy = 1'b1;
        if (cfg_pwrite && cfg_paddr == ACK_REG_ADDR) ack_byte = cfg_pwdata[7:0];
      end
      // Watchdog on cycles with no handshake anywhere.
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** mouse_packet_fifo_aligner_unit: FAILED **");
        $finish;
      end
    end
  end

  // Offer one word, idling first at the sender rate, and wait until it is taken.
  task automatic send_word(input logic mode, input logic [7:0] status, input logic [7:0] data,
                           input logic typed, input pkt_result_t exp_word);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid  <= 1'b1;
    in_tuser   <= mode;
    in_tdata   <= {data, status};
    row_typed  <= typed;
    row_expect <= exp_word;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering words and wait until every expected result word has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    row_typed <= 1'b0;
    do @(negedge clk); while (awaited_results.size() != 0);
    @(posedge clk);
  endtask

  // Register access: setup cycle, then access cycle until pready.
  task automatic cfg_access(input logic wr, input logic [7:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= ACK_REG_ADDR;
    cfg_pwdata  <= {24'h0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (!wr) check_field("ack_code readback", {24'h0, ack_byte}, cfg_prdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [7:0] byte_not_ack();
    logic [7:0] b;
    do b = 8'($urandom); while (b == ack_byte);
    return b;
  endfunction

  function automatic logic [7:0] lead_byte();
    logic [7:0] b;
    do b = (8'($urandom) & LEAD_MASK) | LEAD_SET; while (b == ack_byte);
    return b;
  endfunction

  function automatic logic [7:0] keep_status();
    return 8'($urandom) | STS_KEEP;
  endfunction

  task automatic send_packet();
    send_word(MODE_ARRIVAL, keep_status(), lead_byte(), 1'b0, NO_RESULT);
    send_word(MODE_ARRIVAL, keep_status(), byte_not_ack(), 1'b0, NO_RESULT);
    send_word(MODE_ARRIVAL, keep_status(), byte_not_ack(), 1'b0, NO_RESULT);
  endtask

  task automatic send_read();
    send_word(MODE_READ, 8'($urandom), 8'($urandom), 1'b0, NO_RESULT);
  endtask

  // Mostly whole packets and reads; the rest rejects, ack bytes and framing breaks.
  task automatic random_segment();
    int         pick;
    logic [7:0] s;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 50) begin
      send_packet();
    end else if (pick < 85) begin
      send_read();
    end else if (pick < 89) begin
      s = 8'($urandom);
      case ($urandom_range(2))
        0:       s[STS_READY_BIT] = 1'b0;
        1:       s[STS_AUX_BIT] = 1'b0;
        default: s = s & ~STS_KEEP;
      endcase
      send_word(MODE_ARRIVAL, s, 8'($urandom), 1'b0, NO_RESULT);
    end else if (pick < 92) begin
      send_word(MODE_ARRIVAL, keep_status(), ack_byte, 1'b0, NO_RESULT);
    end else if (pick < 96) begin
      do b = 8'($urandom); while (is_lead(b) || b == ack_byte);
      send_word(MODE_ARRIVAL, keep_status(), b, 1'b0, NO_RESULT);
    end else begin
      send_word(MODE_ARRIVAL, keep_status(), byte_not_ack(), 1'b0, NO_RESULT);
    end
  endtask

  // Main sequence.
  initial begin
    int ph;
    int k;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_access(1'b0, 8'h00);

    // Directed table at the reset value of the acknowledge byte.
    for (k = 0; k < DIR_ROWS; k++) begin
      send_word(DIRECTED[k].mode, DIRECTED[k].status, DIRECTED[k].data,
                DIRECTED[k].typed, DIRECTED[k].expect_word);
    end
    drain_results();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = PH_SEND_IDLE[ph];
      recv_stall_pct = PH_RECV_STALL[ph];
      case (ph)
        0:       cfg_access(1'b1, 8'h00);
        1:       cfg_access(1'b1, 8'hFF);
        default: cfg_access(1'b1, 8'($urandom));
      endcase
      cfg_access(1'b0, 8'h00);

      if (ph == 0) begin
        // Fill the ring to the brim so the write pointer wraps, then overfill:
        // the arrival after a full ring empties it first.
        repeat (RING_PACKETS) send_packet();
        send_word(MODE_ARRIVAL, keep_status(), byte_not_ack(), 1'b0, NO_RESULT);
      end

      for (k = 0; k < SEGS_PER_PH; k++) begin
        random_segment();
        if (ph == NUM_PHASES - 1 && k == SEGS_PER_PH / 2) drain_results();
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d result words never arrived", awaited_results.size());
      fail_count++;
    end

    $display("Covered %0d words over %0d idling settings: %0d packets returned, %0d flushes.",
             words_taken, NUM_PHASES, packets_seen, flushes_seen);
    $display("Included rejects, ack bytes, short reads, misalignment, overfill and wrap.");
    if (fail_count == 0) begin
      $display("** mouse_packet_fifo_aligner_unit: PASSED **");
    end else begin
      $display("** mouse_packet_fifo_aligner_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mpfa_pkg.sv
rtl/mpfa_ctrl.sv
rtl/mpfa_dp.sv
rtl/mouse_packet_fifo_aligner_unit.sv
rtl/mpfa_checker.sv
tb/sv/testbench.sv
